// ----- design/psl_pkg.sv -----
// ----------------------------------------------------------------------------
// psl_pkg
// Shared types and constants of the packet sequence loss tracker.
// ----------------------------------------------------------------------------
package psl_pkg;

  // Width of the packet identifier field and of the configuration registers.
  localparam int unsigned IdW = 16;

  // Configuration register indexes.
  localparam logic CfgCommandId   = 1'b0;
  localparam logic CfgHeartbeatId = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [IdW-1:0] CommandIdReset   = 16'hFFFF;
  localparam logic [IdW-1:0] HeartbeatIdReset = 16'hFFFE;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_GAP,
    ST_RESEND
  } psl_state_e;

endpackage

// ----- design/psl_ram.sv -----
// ----------------------------------------------------------------------------
// psl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module psl_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/packet_sequence_loss_tracker.sv -----
// ----------------------------------------------------------------------------
// packet_sequence_loss_tracker
// Classifies each received packet identifier and keeps a map of lost data
// identifiers in a one-bit-wide RAM.
// ----------------------------------------------------------------------------
//  channel   | ports                                       | direction
//  ----------+---------------------------------------------+----------
//  request   | start_i, busy_o, packet_id_i, length_ok_i,  | in
//            | resend_active_i                             |
//  result    | result_valid_o and the result field ports   | out
//  config    | cfg_we_i, cfg_addr_i, cfg_wdata_i           | in
//
// A command, heartbeat, bad-length or unknown request gives its result in the
// cycle after acceptance and leaves busy_o low. A data request in resend
// phase reads its lost-map entry, then in ST_RESEND clears it if it was listed
// and gives its result. A data request outside resend phase that skips no
// identifier gives its result in the cycle after acceptance; one that skips
// some walks the gap in ST_GAP, one lost-map entry per cycle via the read port.
// After reset the lost map is cleared, one entry a cycle, with busy_o high.
// Results are shown for one cycle under result_valid_o; the receiver cannot
// stall them.
// ----------------------------------------------------------------------------
module packet_sequence_loss_tracker
  import psl_pkg::*;
#(
  parameter int unsigned MAX_PACKETS = 1024,
  localparam int unsigned AW = $clog2(MAX_PACKETS),
  localparam int unsigned CW = $clog2(MAX_PACKETS + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  // Request side.
  input  logic           start_i,
  output logic           busy_o,
  input  logic [IdW-1:0] packet_id_i,
  input  logic           length_ok_i,
  input  logic           resend_active_i,
  // Configuration port.
  input  logic           cfg_we_i,
  input  logic           cfg_addr_i,
  input  logic [IdW-1:0] cfg_wdata_i,
  // Result side.
  output logic           result_valid_o,
  output logic           command_response_o,
  output logic           link_alive_o,
  output logic           burst_start_o,
  output logic           burst_end_o,
  output logic           check_lost_o,
  output logic           write_enable_o,
  output logic [AW-1:0]  write_slot_o,
  output logic [CW-1:0]  received_count_o,
  output logic [CW-1:0]  lost_count_o
);

  psl_state_e state_q, state_d;

  logic [IdW-1:0] cmd_id_q, hb_id_q;
  logic [AW-1:0]  last_id_q, last_id_d;
  logic           last_valid_q, last_valid_d;
  logic           prev_data_q, prev_data_d;
  logic [CW-1:0]  lost_q, lost_d;
  logic [CW-1:0]  latest_q, latest_d;
  logic [AW-1:0]  id_q, id_d;
  logic [AW-1:0]  ptr_q, ptr_d;
  logic           pend_q, pend_d;
  logic [AW-1:0]  paddr_q, paddr_d;
  logic           bstart_q, bstart_d;
  logic [AW-1:0]  clr_q, clr_d;

  // Result registers.
  logic          out_valid_q, out_valid_d;
  logic          out_cmd_q, out_cmd_d;
  logic          out_alive_q, out_alive_d;
  logic          out_bstart_q, out_bstart_d;
  logic          out_bend_q, out_bend_d;
  logic          out_chk_q, out_chk_d;
  logic          out_wen_q, out_wen_d;
  logic [AW-1:0] out_slot_q, out_slot_d;
  logic [CW-1:0] out_recv_q, out_recv_d;
  logic [CW-1:0] out_lost_q, out_lost_d;

  // Lost-map RAM signals.
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [0:0]    ram_wdata, ram_rdata;

  // Request decode.
  logic          is_cmd, is_hb, in_range, is_data;
  logic [AW-1:0] id_in;
  logic [CW-1:0] gap_start;
  logic          has_gap;

  assign is_cmd   = length_ok_i && (packet_id_i == cmd_id_q);
  assign is_hb    = length_ok_i && !is_cmd && (packet_id_i == hb_id_q);
  assign in_range = {1'b0, packet_id_i} < (IdW + 1)'(MAX_PACKETS);
  assign is_data  = length_ok_i && !is_cmd && !is_hb && in_range;
  assign id_in    = packet_id_i[AW-1:0];

  // First identifier that the new data packet may have skipped.
  assign gap_start = last_valid_q ? (CW'(last_id_q) + CW'(1)) : '0;
  assign has_gap   = CW'(id_in) > gap_start;

  psl_ram #(
    .WIDTH (1),
    .DEPTH (MAX_PACKETS)
  ) u_lost_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_id_q <= CommandIdReset;
      hb_id_q  <= HeartbeatIdReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgCommandId:   cmd_id_q <= cfg_wdata_i;
        CfgHeartbeatId: hb_id_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // State register and control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      last_id_q    <= '0;
      last_valid_q <= 1'b0;
      prev_data_q  <= 1'b0;
      lost_q       <= '0;
      latest_q     <= '0;
      pend_q       <= 1'b0;
      clr_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      last_id_q    <= last_id_d;
      last_valid_q <= last_valid_d;
      prev_data_q  <= prev_data_d;
      lost_q       <= lost_d;
      latest_q     <= latest_d;
      pend_q       <= pend_d;
      clr_q        <= clr_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers of the request in flight and of the result.
  always_ff @(posedge clk_i) begin
    id_q         <= id_d;
    ptr_q        <= ptr_d;
    paddr_q      <= paddr_d;
    bstart_q     <= bstart_d;
    out_cmd_q    <= out_cmd_d;
    out_alive_q  <= out_alive_d;
    out_bstart_q <= out_bstart_d;
    out_bend_q   <= out_bend_d;
    out_chk_q    <= out_chk_d;
    out_wen_q    <= out_wen_d;
    out_slot_q   <= out_slot_d;
    out_recv_q   <= out_recv_d;
    out_lost_q   <= out_lost_d;
  end

  // Next state, lost-map accesses and result.
  always_comb begin
    state_d      = state_q;
    last_id_d    = last_id_q;
    last_valid_d = last_valid_q;
    prev_data_d  = prev_data_q;
    lost_d       = lost_q;
    latest_d     = latest_q;
    id_d         = id_q;
    ptr_d        = ptr_q;
    pend_d       = pend_q;
    paddr_d      = paddr_q;
    bstart_d     = bstart_q;
    clr_d        = clr_q;

    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = '0;

    out_valid_d  = 1'b0;
    out_cmd_d    = 1'b0;
    out_alive_d  = 1'b0;
    out_bstart_d = 1'b0;
    out_bend_d   = 1'b0;
    out_chk_d    = 1'b0;
    out_wen_d    = 1'b0;
    out_slot_d   = '0;
    out_recv_d   = latest_q;
    out_lost_d   = lost_q;

    case (state_q)
      // Sweep the lost map to zero after reset.
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(MAX_PACKETS - 1)) begin
          state_d = ST_IDLE;
        end
      end

      // Accept a request and either answer at once or start a map walk.
      ST_IDLE: begin
        if (start_i) begin
          if (is_data) begin
            id_d         = id_in;
            last_id_d    = id_in;
            last_valid_d = 1'b1;
            prev_data_d  = 1'b1;
            if (resend_active_i) begin
              ram_re    = 1'b1;
              ram_raddr = id_in;
              state_d   = ST_RESEND;
            end else begin
              latest_d = CW'(id_in) + CW'(1);
              bstart_d = !prev_data_q;
              if (has_gap) begin
                ptr_d   = gap_start[AW-1:0];
                pend_d  = 1'b0;
                state_d = ST_GAP;
              end else begin
                out_valid_d  = 1'b1;
                out_alive_d  = 1'b1;
                out_wen_d    = 1'b1;
                out_slot_d   = id_in;
                out_bstart_d = !prev_data_q;
                out_recv_d   = CW'(id_in) + CW'(1);
              end
            end
          end else begin
            // Command, heartbeat, bad length or unknown identifier.
            out_valid_d = 1'b1;
            out_cmd_d   = is_cmd;
            if (is_hb) begin
              out_alive_d = 1'b1;
              prev_data_d = 1'b0;
              if (prev_data_q) begin
                if (resend_active_i) begin
                  out_chk_d = 1'b1;
                end else begin
                  out_bend_d   = 1'b1;
                  last_valid_d = 1'b0;
                  last_id_d    = '0;
                end
              end
            end
          end
        end
      end

      // Mark skipped identifiers lost: read one entry a cycle, set it next cycle.
      ST_GAP: begin
        if (pend_q && !ram_rdata[0]) begin
          ram_we    = 1'b1;
          ram_waddr = paddr_q;
          ram_wdata = 1'b1;
          lost_d    = lost_q + CW'(1);
        end
        if (ptr_q < id_q) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q;
          paddr_d   = ptr_q;
          ptr_d     = ptr_q + AW'(1);
          pend_d    = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            out_valid_d  = 1'b1;
            out_alive_d  = 1'b1;
            out_wen_d    = 1'b1;
            out_slot_d   = id_q;
            out_bstart_d = bstart_q;
            state_d      = ST_IDLE;
          end
        end
      end

      // Resent packet: accept it only if it is listed as lost, then unlist it.
      ST_RESEND: begin
        out_valid_d = 1'b1;
        out_alive_d = 1'b1;
        if (ram_rdata[0]) begin
          ram_we     = 1'b1;
          ram_waddr  = id_q;
          ram_wdata  = 1'b0;
          lost_d     = (lost_q != '0) ? (lost_q - CW'(1)) : lost_q;
          out_wen_d  = 1'b1;
          out_slot_d = id_q;
          out_lost_d = lost_d;
        end
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o             = (state_q != ST_IDLE);
  assign result_valid_o     = out_valid_q;
  assign command_response_o = out_cmd_q;
  assign link_alive_o       = out_alive_q;
  assign burst_start_o      = out_bstart_q;
  assign burst_end_o        = out_bend_q;
  assign check_lost_o       = out_chk_q;
  assign write_enable_o     = out_wen_q;
  assign write_slot_o       = out_slot_q;
  assign received_count_o   = out_recv_q;
  assign lost_count_o       = out_lost_q;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the packet sequence loss tracker.
// A short table of directed packets is followed by random traffic in five
// register settings. Most random traffic is made of well-formed bursts:
// heartbeat, rising data identifiers with skips, heartbeat, then often a resend
// phase that replays lost identifiers. Malformed and unknown packets are mixed
// in. Each result is compared field by field with a bench-side tracker that
// keeps its own lost map and counters, or with the table for typed rows.
// ----------------------------------------------------------------------------
module tb;
  import psl_pkg::*;

  localparam int unsigned MaxPkt        = 1024;
  localparam int unsigned SlotW         = 10;
  localparam int unsigned CntW          = 11;
  localparam int unsigned StallLimit    = 20000;
  localparam int unsigned ItemsPerPhase = 200;
  localparam int unsigned NumPhases     = 5;
  localparam int unsigned DirRows       = 23;
  localparam int unsigned MaxPrinted    = 40;
  localparam int unsigned PendAw        = 4;
  localparam int unsigned PendDepth     = 16;

  typedef struct packed {
    logic             cmd_resp;
    logic             alive;
    logic             b_start;
    logic             b_end;
    logic             chk_lost;
    logic             wr_en;
    logic [SlotW-1:0] slot;
    logic [CntW-1:0]  rx_count;
    logic [CntW-1:0]  lost_cnt;
  } track_result_t;

  typedef struct packed {
    logic [IdW-1:0] id;
    logic           len_ok;
    logic           resend;
    logic           typed;
    track_result_t  res;
  } packet_row_t;

  // Results that can be written down directly after reset.
  localparam track_result_t ResNone  = '0;
  localparam track_result_t ResCmd   =
    '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 10'd0, 11'd0, 11'd0};
  localparam track_result_t ResAlive =
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 10'd0, 11'd0, 11'd0};
  localparam track_result_t ResFirstData =
    '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 10'd0, 11'd1, 11'd0};

  // Directed packets, run with the reset register values.
  packet_row_t dir_tab [DirRows] = '{
    '{CommandIdReset,   1'b1, 1'b0, 1'b1, ResCmd},       // command after reset
    '{HeartbeatIdReset, 1'b0, 1'b0, 1'b1, ResNone},      // bad length
    '{HeartbeatIdReset, 1'b1, 1'b0, 1'b1, ResAlive},     // heartbeat, no data yet
    '{16'h0000,         1'b1, 1'b0, 1'b1, ResFirstData}, // gap starts at zero
    '{16'h0003,         1'b1, 1'b0, 1'b0, ResNone},      // skips two
    '{16'h0003,         1'b1, 1'b0, 1'b0, ResNone},      // repeated identifier
    '{16'h0001,         1'b1, 1'b0, 1'b0, ResNone},      // backward identifier
    '{16'h0005,         1'b1, 1'b0, 1'b0, ResNone},      // marks one already lost
    '{16'h0007,         1'b0, 1'b0, 1'b0, ResNone},      // data with bad length
    '{16'h9C40,         1'b1, 1'b0, 1'b0, ResNone},      // unknown identifier
    '{HeartbeatIdReset, 1'b1, 1'b1, 1'b0, ResNone},      // lost-list check
    '{16'h0002,         1'b1, 1'b1, 1'b0, ResNone},      // listed resend
    '{16'h0002,         1'b1, 1'b1, 1'b0, ResNone},      // no longer listed
    '{16'h03FF,         1'b1, 1'b1, 1'b0, ResNone},      // unlisted resend
    '{HeartbeatIdReset, 1'b1, 1'b0, 1'b0, ResNone},      // burst end
    '{16'h03FF,         1'b1, 1'b0, 1'b0, ResNone},      // highest data identifier
    '{HeartbeatIdReset, 1'b1, 1'b1, 1'b0, ResNone},      // lost-list check
    '{16'h0400,         1'b1, 1'b0, 1'b0, ResNone},      // just above data range
    '{CommandIdReset,   1'b0, 1'b1, 1'b0, ResNone},      // command, bad length
    '{CommandIdReset,   1'b1, 1'b1, 1'b0, ResNone},      // command in resend
    '{HeartbeatIdReset, 1'b1, 1'b0, 1'b0, ResNone},      // heartbeat after heartbeat
    '{16'h0000,         1'b1, 1'b1, 1'b0, ResNone},      // resend clears entry zero
    '{16'h8000,         1'b1, 1'b1, 1'b0, ResNone}       // unknown in resend
  };

  // Block ports.
  logic             clk_i;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  logic [IdW-1:0]   packet_id_i;
  logic             length_ok_i;
  logic             resend_active_i;
  logic             cfg_we_i;
  logic             cfg_addr_i;
  logic [IdW-1:0]   cfg_wdata_i;
  logic             result_valid_o;
  logic             command_response_o;
  logic             link_alive_o;
  logic             burst_start_o;
  logic             burst_end_o;
  logic             check_lost_o;
  logic             write_enable_o;
  logic [SlotW-1:0] write_slot_o;
  logic [CntW-1:0]  received_count_o;
  logic [CntW-1:0]  lost_count_o;

  // Bench copy of the registers and the tracking state.
  logic [IdW-1:0]  cmd_reg;
  logic [IdW-1:0]  hb_reg;
  logic [CntW-1:0] last_id;
  logic            last_valid;
  logic            prev_data;
  logic            lost_map [MaxPkt];
  logic [CntW-1:0] lost_total;
  logic [CntW-1:0] latest_count;

  // Expected results of accepted requests, oldest first.
  track_result_t     pend_mem [PendDepth];
  logic [PendAw-1:0] pend_wr;
  logic [PendAw-1:0] pend_rd;
  int unsigned       pend_cnt;

  track_result_t   got_res;
  track_result_t   want_res;
  track_result_t   pred_res;
  logic            row_typed;
  track_result_t   row_expect;

  int unsigned n_sent;
  int unsigned n_accepted;
  int unsigned n_results;
  int unsigned n_errors;
  int unsigned n_bursts;
  int unsigned n_burst_ends;
  int unsigned n_checks;
  int unsigned n_replays;
  int unsigned stall_cycles;

  packet_sequence_loss_tracker u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .packet_id_i        (packet_id_i),
    .length_ok_i        (length_ok_i),
    .resend_active_i    (resend_active_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_addr_i         (cfg_addr_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .result_valid_o     (result_valid_o),
    .command_response_o (command_response_o),
    .link_alive_o       (link_alive_o),
    .burst_start_o      (burst_start_o),
    .burst_end_o        (burst_end_o),
    .check_lost_o       (check_lost_o),
    .write_enable_o     (write_enable_o),
    .write_slot_o       (write_slot_o),
    .received_count_o   (received_count_o),
    .lost_count_o       (lost_count_o)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Classifies one packet, updates the lost map and returns the result.
  function automatic track_result_t track_packet(input logic [IdW-1:0] id,
                                                 input logic len_ok,
                                                 input logic resend);
    track_result_t r;
    int unsigned   first;
    int unsigned   i;
    r = '0;
    if (len_ok) begin
      if (id == cmd_reg) begin
        r.cmd_resp = 1'b1;
      end else if (id == hb_reg) begin
        r.alive = 1'b1;
        if (prev_data) begin
          if (resend) begin
            r.chk_lost = 1'b1;
          end else begin
            last_valid = 1'b0;
            last_id    = '0;
            r.b_end    = 1'b1;
          end
        end
        prev_data = 1'b0;
      end else if (id < MaxPkt) begin
        r.alive = 1'b1;
        if (resend) begin
          // Only identifiers on the lost list are taken back.
          if (lost_map[id[SlotW-1:0]]) begin
            lost_map[id[SlotW-1:0]] = 1'b0;
            if (lost_total != 0) lost_total = lost_total - 1'b1;
            r.wr_en = 1'b1;
          end
        end else begin
          r.wr_en      = 1'b1;
          latest_count = id[CntW-1:0] + 1'b1;
          first        = last_valid ? 32'(last_id) + 32'd1 : 32'd0;
          for (i = first; i < id; i++) begin
            if (!lost_map[i]) begin
              lost_map[i] = 1'b1;
              lost_total  = lost_total + 1'b1;
            end
          end
          if (!prev_data) r.b_start = 1'b1;
        end
        if (r.wr_en) r.slot = id[SlotW-1:0];
        last_id    = id[CntW-1:0];
        last_valid = 1'b1;
        prev_data  = 1'b1;
      end
    end
    r.rx_count = latest_count;
    r.lost_cnt = lost_total;
    return r;
  endfunction

  // Prints one mismatch line (up to a cap) and counts it.
  task automatic report_mismatch(input string what, input logic [CntW-1:0] got,
                                 input logic [CntW-1:0] want);
    n_errors++;
    if (n_errors <= MaxPrinted) begin
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  // Result checking, register tracking and request prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) begin
        n_results++;
        got_res = '{command_response_o, link_alive_o, burst_start_o, burst_end_o,
                    check_lost_o, write_enable_o, write_slot_o, received_count_o,
                    lost_count_o};
        if (pend_cnt == 0) begin
          report_mismatch("result with no request pending", '0, '0);
        end else begin
          want_res = pend_mem[pend_rd];
          pend_rd  = pend_rd + 1'b1;
          pend_cnt--;
          if (got_res.cmd_resp !== want_res.cmd_resp)
            report_mismatch("command_response", CntW'(got_res.cmd_resp),
                            CntW'(want_res.cmd_resp));
          if (got_res.alive !== want_res.alive)
            report_mismatch("link_alive", CntW'(got_res.alive), CntW'(want_res.alive));
          if (got_res.b_start !== want_res.b_start)
            report_mismatch("burst_start", CntW'(got_res.b_start),
                            CntW'(want_res.b_start));
          if (got_res.b_end !== want_res.b_end)
            report_mismatch("burst_end", CntW'(got_res.b_end), CntW'(want_res.b_end));
          if (got_res.chk_lost !== want_res.chk_lost)
            report_mismatch("check_lost", CntW'(got_res.chk_lost),
                            CntW'(want_res.chk_lost));
          if (got_res.wr_en !== want_res.wr_en)
            report_mismatch("write_enable", CntW'(got_res.wr_en), CntW'(want_res.wr_en));
          if (got_res.slot !== want_res.slot)
            report_mismatch("write_slot", CntW'(got_res.slot), CntW'(want_res.slot));
          if (got_res.rx_count !== want_res.rx_count)
            report_mismatch("received_count", got_res.rx_count, want_res.rx_count);
          if (got_res.lost_cnt !== want_res.lost_cnt)
            report_mismatch("lost_count", got_res.lost_cnt, want_res.lost_cnt);
        end
      end
      if (cfg_we_i) begin
        if (cfg_addr_i == CfgCommandId) cmd_reg = cfg_wdata_i;
        else hb_reg = cfg_wdata_i;
      end
      if (start_i && !busy_o) begin
        n_accepted++;
        pred_res = track_packet(packet_id_i, length_ok_i, resend_active_i);
        if (pend_cnt >= PendDepth) begin
          report_mismatch("too many results outstanding", CntW'(pend_cnt), '0);
        end else begin
          pend_mem[pend_wr] = row_typed ? row_expect : pred_res;
          pend_wr           = pend_wr + 1'b1;
          pend_cnt++;
        end
        if (pred_res.b_start) n_bursts++;
        if (pred_res.b_end) n_burst_ends++;
        if (pred_res.chk_lost) n_checks++;
        if (pred_res.wr_en && resend_active_i) n_replays++;
      end
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || result_valid_o) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("[%0t] no progress for %0d cycles", $time, StallLimit);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Presents one request, idling at random before it, and waits for acceptance.
  task automatic send_packet(input logic [IdW-1:0] id, input logic len_ok,
                             input logic resend, input logic typed,
                             input track_result_t want);
    logic idle_ok;
    idle_ok = !(n_sent >= 400 && n_sent < 550);
    while (idle_ok && ($urandom_range(99) < 13)) begin
      @(negedge clk_i);
      start_i     <= 1'b0;
      packet_id_i <= IdW'($urandom);
    end
    @(negedge clk_i);
    start_i         <= 1'b1;
    packet_id_i     <= id;
    length_ok_i     <= len_ok;
    resend_active_i <= resend;
    row_typed  = typed;
    row_expect = want;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    n_sent++;
  endtask

  // Stops requests and waits until every result is in and the block is idle.
  task automatic settle_block();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pend_cnt != 0 || busy_o !== 1'b0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic addr, input logic [IdW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Picks a resend identifier, mostly one that is on the lost list.
  function automatic logic [IdW-1:0] pick_resend_id();
    int unsigned base;
    int unsigned k;
    base = $urandom_range(MaxPkt - 1);
    if ($urandom_range(4) != 0) begin
      for (k = 0; k < MaxPkt; k++) begin
        if (lost_map[(base + k) % MaxPkt]) return IdW'((base + k) % MaxPkt);
      end
    end
    return IdW'(base);
  endfunction

  // One well-formed burst: heartbeat, rising data identifiers with skips,
  // closing heartbeat, and often a resend phase ending in a lost-list check.
  task automatic run_burst_cycle();
    int unsigned id;
    int unsigned step;
    int unsigned n;
    int unsigned r;
    send_packet(hb_reg, 1'b1, 1'b0, 1'b0, ResNone);
    id = $urandom_range(3);
    n  = $urandom_range(24, 1);
    while (n != 0 && id < MaxPkt) begin
      send_packet(IdW'(id), $urandom_range(49) != 0, 1'b0, 1'b0, ResNone);
      r    = $urandom_range(99);
      step = (r < 70) ? 1 : (r < 95) ? $urandom_range(6, 2) : $urandom_range(400, 7);
      id   = id + step;
      n--;
    end
    send_packet(hb_reg, 1'b1, 1'b0, 1'b0, ResNone);
    if ($urandom_range(3) != 0) begin
      repeat ($urandom_range(8, 1)) begin
        send_packet(pick_resend_id(), $urandom_range(29) != 0, 1'b1, 1'b0, ResNone);
      end
      send_packet(hb_reg, 1'b1, 1'b1, 1'b0, ResNone);
    end
  endtask

  // One packet of noise: random identifiers, commands, stray heartbeats and
  // data out of order, with random flags.
  task automatic send_noise();
    int unsigned r;
    logic        len_ok;
    logic        resend;
    r      = $urandom_range(99);
    len_ok = $urandom_range(9) != 0;
    resend = 1'($urandom_range(1));
    if (r < 40) send_packet(IdW'($urandom), 1'($urandom_range(1)), resend, 1'b0, ResNone);
    else if (r < 55) send_packet(cmd_reg, len_ok, resend, 1'b0, ResNone);
    else if (r < 70) send_packet(hb_reg, len_ok, resend, 1'b0, ResNone);
    else send_packet(IdW'($urandom_range(MaxPkt - 1)), len_ok, resend, 1'b0, ResNone);
  endtask

  // Main sequence.
  initial begin
    int unsigned goal;
    int unsigned phase;
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    packet_id_i     = '0;
    length_ok_i     = 1'b0;
    resend_active_i = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_addr_i      = CfgCommandId;
    cfg_wdata_i     = '0;
    cmd_reg         = CommandIdReset;
    hb_reg          = HeartbeatIdReset;
    last_id         = '0;
    last_valid      = 1'b0;
    prev_data       = 1'b0;
    lost_total      = '0;
    latest_count    = '0;
    foreach (lost_map[i]) lost_map[i] = 1'b0;
    pend_wr         = '0;
    pend_rd         = '0;
    pend_cnt        = 0;
    row_typed       = 1'b0;
    row_expect      = ResNone;
    n_sent          = 0;
    n_accepted      = 0;
    n_results       = 0;
    n_errors        = 0;
    n_bursts        = 0;
    n_burst_ends    = 0;
    n_checks        = 0;
    n_replays       = 0;
    stall_cycles    = 0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table with the reset register values.
    foreach (dir_tab[i]) begin
      send_packet(dir_tab[i].id, dir_tab[i].len_ok, dir_tab[i].resend,
                  dir_tab[i].typed, dir_tab[i].res);
    end

    // Random traffic under several register settings.
    for (phase = 0; phase < NumPhases; phase++) begin
      settle_block();
      case (phase)
        1: begin
          write_reg(CfgCommandId, 16'h0000);
          write_reg(CfgHeartbeatId, 16'hFFFF);
        end
        2: begin
          // Heartbeat inside the data range.
          write_reg(CfgCommandId, IdW'($urandom_range(65535, MaxPkt)));
          write_reg(CfgHeartbeatId, IdW'($urandom_range(MaxPkt - 1)));
        end
        3: begin
          write_reg(CfgCommandId, IdW'($urandom));
          write_reg(CfgHeartbeatId, IdW'($urandom));
        end
        4: begin
          // Equal identifiers: the command match wins.
          write_reg(CfgCommandId, 16'h0200);
          write_reg(CfgHeartbeatId, 16'h0200);
        end
        default: begin
        end
      endcase
      goal = n_sent + ItemsPerPhase;
      while (n_sent < goal) begin
        if ($urandom_range(99) < 75) run_burst_cycle();
        else send_noise();
      end
    end

    settle_block();
    repeat (16) @(posedge clk_i);
    if (pend_cnt != 0) report_mismatch("results never arrived", CntW'(pend_cnt), '0);

    $display("Run covered %0d requests (%0d directed) and %0d results in %0d settings.",
             n_accepted, DirRows, n_results, NumPhases);
    $display("Bursts started %0d, ended %0d; lost-list checks %0d; resend writes %0d.",
             n_bursts, n_burst_ends, n_checks, n_replays);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- packet_sequence_loss_tracker.f -----
design/psl_pkg.sv
design/psl_ram.sv
design/packet_sequence_loss_tracker.sv
tb/tb.sv
